// File: rtl/twtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtb_pkg
// Shared types and constants of the time window track buffer.
// ----------------------------------------------------------------------------
package twtb_pkg;

  localparam int WINDOW_W     = 14;
  localparam int MAXCFG_W     = 13;
  localparam int CFG_DATA_W   = 14;
  localparam int SPAN_W       = 26;
  localparam int STAMP_W      = 40;
  localparam int ID_W         = 32;
  localparam int RCOUNT_W     = 13;
  localparam int INDEX_W      = 12;
  localparam int SEC_PER_HOUR = 3600;
  localparam int WINDOW_RST   = 24;
  localparam int MAXCFG_RST   = 4096;

  typedef enum logic [0:0] {
    CFG_WINDOW = 1'b0,
    CFG_MAX    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_PRUNE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REJECTED = 3'd1,
    ST_PRUNED   = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef logic [SPAN_W-1:0] span_t;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic [15:0]         speed;
    logic [STAMP_W-1:0]  stamp;
    logic [INDEX_W-1:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [ID_W-1:0]     point_id;
    logic [ID_W-1:0]     removed_first_id;
    logic [RCOUNT_W-1:0] removed_count;
    logic signed [31:0]  out_x;
    logic signed [31:0]  out_y;
    logic [15:0]         out_speed;
    logic [STAMP_W-1:0]  out_stamp;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0]  x;
    logic signed [31:0]  y;
    logic [15:0]         speed;
    logic [STAMP_W-1:0]  stamp;
    logic [ID_W-1:0]     id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/twtb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtb_in_if
// Command channel: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface twtb_in_if;
  import twtb_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);

endinterface

// File: rtl/twtb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtb_out_if
// Result channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface twtb_out_if;
  import twtb_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);

endinterface

// File: rtl/twtb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtb_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module twtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/twtb_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtb_engine
// Ring buffer sequencer: add, read and one-per-cycle eviction of oldest words.
// ----------------------------------------------------------------------------
module twtb_engine #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  twtb_in_if.sink                              in_i,
  twtb_out_if.source                           out_o,
  input  twtb_pkg::span_t                      span_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     limit_i
);
  import twtb_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(MAX_ENTRIES);
  localparam logic [CW-1:0] DEPTH_C = CW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVRD,
    S_EVCHK,
    S_READ,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      oldest_q;
  logic [CW-1:0]      count_q;
  logic [ID_W-1:0]    id_q;
  logic [STAMP_W-1:0] newest_q;
  logic [STAMP_W-1:0] border_q;
  logic               time_en_q;
  logic               ev_any_q;
  logic [ID_W-1:0]    ev_first_q;
  logic [RCOUNT_W-1:0] ev_count_q;
  status_e            status_q;
  logic [ID_W-1:0]    pid_q;
  entry_t             ent_q;
  logic               out_valid_q;
  out_word_t          out_word_q;

  logic               acc;
  logic               add_ok;
  logic               add_full;
  logic               full;
  logic               read_ok;
  logic               drop;
  logic               out_free;
  logic [AW-1:0]      wr_slot;
  logic [AW-1:0]      rd_slot;
  logic [AW-1:0]      next_oldest;
  logic [ID_W-1:0]    oldest_id;
  logic [ID_W-1:0]    new_id;
  logic [XW-1:0]      idx_x;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             wr_ent;
  entry_t             rd_ent;

  function automatic logic [AW-1:0] wrap_slot(logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_W) ? s - DEPTH_W : s;
    return r[AW-1:0];
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;
  assign rd_ent      = entry_t'(ram_rdata);

  always_comb begin
    acc         = in_i.valid && (state_q == S_IDLE);
    full        = (count_q == DEPTH_C);
    add_ok      = (count_q == '0) || (in_i.word.stamp >= newest_q);
    idx_x       = XW'(in_i.word.read_index);
    read_ok     = idx_x < XW'(count_q);
    wr_slot     = wrap_slot({1'b0, oldest_q} + (AW+1)'(count_q));
    rd_slot     = wrap_slot({1'b0, oldest_q} + (AW+1)'(idx_x[AW-1:0]));
    next_oldest = wrap_slot({1'b0, oldest_q} + (AW+1)'(1));
    oldest_id   = id_q - ID_W'(count_q) + ID_W'(1);
    new_id      = id_q + ID_W'(1);
    drop        = (time_en_q && (rd_ent.stamp < border_q)) || (count_q > limit_i);
    out_free    = !out_valid_q || out_o.ready;
    wr_ent      = '{x: in_i.word.pos_x, y: in_i.word.pos_y, speed: in_i.word.speed,
                    stamp: in_i.word.stamp, id: new_id};
    ram_we      = acc && (op_e'(in_i.word.op) == OP_ADD) && add_ok;
    add_full    = ram_we && full;
    ram_re      = 1'b0;
    ram_raddr   = oldest_q;
    unique case (state_q)
      S_IDLE: begin
        ram_re    = acc && (op_e'(in_i.word.op) == OP_READ) && read_ok;
        ram_raddr = rd_slot;
      end
      S_EVRD: begin
        ram_re    = (count_q != '0);
      end
      S_EVCHK: begin
        ram_re    = drop && (count_q != CW'(1));
        ram_raddr = next_oldest;
      end
      default: begin
        ram_re    = 1'b0;
      end
    endcase
  end

  twtb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_slot),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      id_q        <= '0;
      newest_q    <= '0;
      border_q    <= '0;
      time_en_q   <= 1'b0;
      ev_any_q    <= 1'b0;
      ev_first_q  <= '0;
      ev_count_q  <= '0;
      status_q    <= ST_PRUNED;
      pid_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            ev_any_q   <= add_full;
            ev_first_q <= add_full ? oldest_id : '0;
            ev_count_q <= add_full ? RCOUNT_W'(1) : '0;
            pid_q      <= ram_we ? new_id : '0;
            unique case (op_e'(in_i.word.op))
              OP_ADD: begin
                if (!add_ok) begin
                  status_q <= ST_REJECTED;
                  state_q  <= S_DONE;
                end else begin
                  // drop the oldest first when the store is full
                  if (full) begin
                    oldest_q <= next_oldest;
                  end else begin
                    count_q <= count_q + CW'(1);
                  end
                  id_q      <= new_id;
                  newest_q  <= in_i.word.stamp;
                  border_q  <= in_i.word.stamp - STAMP_W'(span_i);
                  time_en_q <= in_i.word.stamp >= STAMP_W'(span_i);
                  status_q  <= ST_ADDED;
                  state_q   <= S_EVRD;
                end
              end
              OP_READ: begin
                if (read_ok) begin
                  status_q <= ST_READ_OK;
                  state_q  <= S_READ;
                end else begin
                  status_q <= ST_RANGE;
                  state_q  <= S_DONE;
                end
              end
              default: begin
                border_q  <= newest_q - STAMP_W'(span_i);
                time_en_q <= (count_q != '0) && (newest_q >= STAMP_W'(span_i));
                status_q  <= ST_PRUNED;
                state_q   <= S_EVRD;
              end
            endcase
          end
        end
        S_EVRD: begin
          state_q <= (count_q != '0) ? S_EVCHK : S_DONE;
        end
        S_EVCHK: begin
          if (drop) begin
            if (!ev_any_q) begin
              ev_any_q   <= 1'b1;
              ev_first_q <= oldest_id;
            end
            ev_count_q <= ev_count_q + RCOUNT_W'(1);
            oldest_q   <= next_oldest;
            count_q    <= count_q - CW'(1);
            if (count_q == CW'(1)) begin
              state_q <= S_DONE;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_READ: begin
          pid_q   <= rd_ent.id;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q <= '0;
    end else if (state_q == S_READ) begin
      ent_q <= rd_ent;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_word_q.status           <= status_q;
      out_word_q.point_id         <= pid_q;
      out_word_q.removed_first_id <= ev_first_q;
      out_word_q.removed_count    <= ev_count_q;
      out_word_q.out_x            <= ent_q.x;
      out_word_q.out_y            <= ent_q.y;
      out_word_q.out_speed        <= ent_q.speed;
      out_word_q.out_stamp        <= ent_q.stamp;
    end
  end

endmodule

// File: rtl/time_window_track_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_track_buffer
// Sliding time window store of track points with sequential ids.
//
// Commands arrive on in_i (add, prune, read); one result word per command
// leaves on out_o. Window and count limit are written on the cfg port, by
// the user only while the block is idle; the block does not enforce this.
// The window is turned into seconds at the write. Points sit in one RAM
// with a registered read. A read goes from acceptance through S_READ and
// S_DONE to the output register. An add or prune goes through S_EVRD and,
// with points stored, the eviction walk in S_EVCHK, which reads the oldest
// point once per cycle; then S_DONE. A rejected add or an out of range read
// goes straight to S_DONE. One command is in work at a time; the result
// waits in an output register while the receiver stalls, and the next
// command is taken meanwhile, its own result held until the register frees.
// Reset empties the buffer, zeroes the id counter and restores a 24 hour
// window with a limit of 4096 points (or the depth, if smaller). RAM
// contents are not cleared: only live points are ever read.
// ----------------------------------------------------------------------------
module time_window_track_buffer #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  twtb_in_if.sink                           in_i,
  twtb_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  twtb_pkg::cfg_idx_e                cfg_idx_i,
  input  logic [twtb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import twtb_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] LIMIT_RST =
    CW'((MAXCFG_RST < MAX_ENTRIES) ? MAXCFG_RST : MAX_ENTRIES);
  localparam span_t SPAN_RST = SPAN_W'(WINDOW_RST * SEC_PER_HOUR);
  localparam int MW = (CW > MAXCFG_W) ? CW : MAXCFG_W;

  span_t         span_q;
  logic [CW-1:0] limit_q;
  logic [MW-1:0] max_x;

  assign max_x = MW'(cfg_data_i[MAXCFG_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q  <= SPAN_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW: begin
          span_q <= SPAN_W'(cfg_data_i[WINDOW_W-1:0]) * SPAN_W'(SEC_PER_HOUR);
        end
        CFG_MAX: begin
          // clip the limit to the store depth
          limit_q <= (max_x >= MW'(MAX_ENTRIES)) ? DEPTH_C : CW'(max_x);
        end
      endcase
    end
  end

  twtb_engine #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .span_i  (span_q),
    .limit_i (limit_q)
  );

endmodule

// File: test/tb_time_window_track_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_window_track_buffer
// Self-checking bench for the time window track buffer. A queue of commands
// feeds a valid/ready driver. A monitor keeps its own copy of the ring store,
// predicts the result word of every accepted command and checks each result
// field against the oldest prediction. Phases vary window and limit, the
// pacing on both channels, and hold the result channel off long enough to
// stall the command channel.
// ----------------------------------------------------------------------------
module tb_time_window_track_buffer;
  import twtb_pkg::*;

  localparam int          DEPTH       = 4096;
  localparam int          CLK_HALF    = 4;
  localparam int          HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam logic [STAMP_W-1:0] STAMP_TOP = 40'hFF_FFFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cmd_valid = 1'b0;
  in_word_t              cmd_word  = '0;
  logic                  res_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_idx_e              cfg_idx   = CFG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  twtb_in_if  cmd_if ();
  twtb_out_if res_if ();

  assign cmd_if.valid = cmd_valid;
  assign cmd_if.word  = cmd_word;
  assign res_if.ready = res_ready;

  time_window_track_buffer #(
    .MAX_ENTRIES(DEPTH)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (cmd_if),
    .out_o     (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Predicted store and configuration
  entry_t              trk_mem [DEPTH];
  int unsigned         trk_head    = 0;
  int unsigned         trk_count   = 0;
  logic [ID_W-1:0]     trk_last_id = '0;
  logic [WINDOW_W-1:0] win_hours   = WINDOW_RST[WINDOW_W-1:0];
  logic [MAXCFG_W-1:0] keep_limit  = MAXCFG_RST[MAXCFG_W-1:0];
  logic [ID_W-1:0]     ev_first;
  int unsigned         ev_num;

  in_word_t            cmd_queue [$];
  out_word_t           pending_results [$];
  logic [STAMP_W-1:0]  gen_stamp = '0;

  int          send_idle     = 0;
  int          recv_stall    = 0;
  int          hold_req      = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  logic        cmd_taken     = 1'b0;
  int          cycles        = 0;
  int          fail_count    = 0;
  int          checked       = 0;
  int          accepted      = 0;
  int          evicted_total = 0;
  int unsigned peak_fill     = 0;
  int          status_seen [8] = '{default: 0};

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned slot_at(int unsigned age);
    return (trk_head + age) % DEPTH;
  endfunction

  task automatic drop_front();
    if (trk_count != 0) begin
      if (ev_num == 0) ev_first = trk_mem[trk_head].id;
      ev_num    = ev_num + 1;
      trk_head  = (trk_head + 1) % DEPTH;
      trk_count = trk_count - 1;
    end
  endtask

  task automatic evict_old();
    logic [STAMP_W-1:0] newest;
    logic [STAMP_W-1:0] span;
    int unsigned        cap;
    if (trk_count != 0) begin
      newest = trk_mem[slot_at(trk_count - 1)].stamp;
      span   = STAMP_W'(win_hours) * STAMP_W'(SEC_PER_HOUR);
      if (newest >= span) begin
        while (trk_count != 0 && trk_mem[trk_head].stamp < newest - span) drop_front();
      end
    end
    cap = (keep_limit < DEPTH) ? keep_limit : DEPTH;
    while (trk_count > cap) drop_front();
  endtask

  task automatic predict(input in_word_t cmd, output out_word_t res);
    int unsigned slot;
    res      = '0;
    ev_first = '0;
    ev_num   = 0;
    case (cmd.op)
      OP_ADD: begin
        if (trk_count != 0 && cmd.stamp < trk_mem[slot_at(trk_count - 1)].stamp) begin
          res.status = ST_REJECTED;
        end else begin
          if (trk_count >= DEPTH) drop_front();
          trk_last_id = trk_last_id + 1'b1;
          slot = slot_at(trk_count);
          trk_mem[slot].x     = cmd.pos_x;
          trk_mem[slot].y     = cmd.pos_y;
          trk_mem[slot].speed = cmd.speed;
          trk_mem[slot].stamp = cmd.stamp;
          trk_mem[slot].id    = trk_last_id;
          trk_count  = trk_count + 1;
          res.status   = ST_ADDED;
          res.point_id = trk_last_id;
          evict_old();
        end
      end
      OP_READ: begin
        if (cmd.read_index < trk_count) begin
          slot = slot_at(cmd.read_index);
          res.status    = ST_READ_OK;
          res.point_id  = trk_mem[slot].id;
          res.out_x     = trk_mem[slot].x;
          res.out_y     = trk_mem[slot].y;
          res.out_speed = trk_mem[slot].speed;
          res.out_stamp = trk_mem[slot].stamp;
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: begin
        res.status = ST_PRUNED;
        evict_old();
      end
    endcase
    res.removed_first_id = ev_first;
    res.removed_count    = ev_num[RCOUNT_W-1:0];
  endtask

  function automatic string fmt_res(out_word_t r);
    return $sformatf("{st %0d id %0d rm %0d+%0d x %h y %h spd %0d t %0d}",
                     r.status, r.point_id, r.removed_first_id, r.removed_count,
                     r.out_x, r.out_y, r.out_speed, r.out_stamp);
  endfunction

  task automatic flag(string msg);
    fail_count = fail_count + 1;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Driver: advance to the next word once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!cmd_valid || cmd_taken)) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        cmd_word  <= cmd_queue.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result channel back-pressure
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Monitor: check result words, predict accepted commands
  always @(posedge clk) begin
    out_word_t exp_res;
    out_word_t got_res;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("** time_window_track_buffer: FAILED **");
      $finish;
    end else begin
      cycles = cycles + 1;
      cmd_taken <= cmd_valid && cmd_if.ready;
      if (rst_n) begin
        if (res_if.valid && res_ready) begin
          got_res = res_if.word;
          checked = checked + 1;
          if (pending_results.size() == 0) begin
            flag($sformatf("result word with nothing pending: %s", fmt_res(got_res)));
          end else begin
            exp_res = pending_results.pop_front();
            if (got_res.status !== exp_res.status ||
                got_res.point_id !== exp_res.point_id ||
                got_res.removed_first_id !== exp_res.removed_first_id ||
                got_res.removed_count !== exp_res.removed_count ||
                got_res.out_x !== exp_res.out_x ||
                got_res.out_y !== exp_res.out_y ||
                got_res.out_speed !== exp_res.out_speed ||
                got_res.out_stamp !== exp_res.out_stamp) begin
              flag($sformatf("mismatch: expected %s got %s", fmt_res(exp_res),
                             fmt_res(got_res)));
            end
          end
        end
        if (cmd_valid && cmd_if.ready) begin
          predict(cmd_word, exp_res);
          pending_results.insert(pending_results.size(), exp_res);
          accepted = accepted + 1;
          status_seen[exp_res.status] = status_seen[exp_res.status] + 1;
          evicted_total = evicted_total + exp_res.removed_count;
          if (trk_count > peak_fill) peak_fill = trk_count;
        end
      end
    end
  end

  function automatic in_word_t noise_word();
    in_word_t w;
    w.op         = OP_PRUNE;
    w.pos_x      = $urandom();
    w.pos_y      = $urandom();
    w.speed      = 16'($urandom());
    w.stamp      = {8'($urandom()), $urandom()};
    w.read_index = 12'($urandom());
    return w;
  endfunction

  task automatic push_point(logic [STAMP_W-1:0] t, logic [31:0] x, logic [31:0] y,
                            logic [15:0] spd);
    in_word_t w;
    w       = noise_word();
    w.op    = OP_ADD;
    w.stamp = t;
    w.pos_x = x;
    w.pos_y = y;
    w.speed = spd;
    cmd_queue.insert(cmd_queue.size(), w);
  endtask

  task automatic push_cmd(logic [1:0] op, logic [INDEX_W-1:0] idx);
    in_word_t w;
    w            = noise_word();
    w.op         = op;
    w.read_index = idx;
    cmd_queue.insert(cmd_queue.size(), w);
  endtask

  task automatic advance_stamp(int unsigned step);
    logic [STAMP_W:0] sum;
    sum       = {1'b0, gen_stamp} + step;
    gen_stamp = sum[STAMP_W] ? STAMP_TOP : sum[STAMP_W-1:0];
  endtask

  // Mostly ordered adds, with late points, reads, prunes and the spare op
  task automatic gen_mix(int count, int unsigned step_max, int unsigned idx_max);
    int unsigned pick;
    int unsigned back;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        advance_stamp((pick < 2) ? step_max * 40 : $urandom_range(0, step_max));
        push_point(gen_stamp, $urandom(), $urandom(), 16'($urandom()));
      end else if (pick < 70) begin
        back = $urandom_range(1, step_max);
        push_point((gen_stamp > back) ? gen_stamp - back : '0, $urandom(), $urandom(),
                   16'($urandom()));
      end else if (pick < 82) begin
        push_cmd(OP_READ, 12'($urandom_range(0, idx_max)));
      end else if (pick < 88) begin
        push_cmd(OP_READ, 12'($urandom()));
      end else if (pick < 91) begin
        push_cmd(OP_SPARE, 12'($urandom()));
      end else begin
        push_cmd(OP_PRUNE, 12'($urandom()));
      end
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we   = 1'b0;
    if (idx == CFG_WINDOW) win_hours = value[WINDOW_W-1:0];
    else keep_limit = value[MAXCFG_W-1:0];
  endtask

  task automatic drain();
    while (cmd_queue.size() != 0 || cmd_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, field extremes, window border, late points
    push_cmd(OP_READ, '0);
    push_cmd(OP_PRUNE, '0);
    push_cmd(OP_SPARE, '0);
    push_point('0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    push_point('0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    push_cmd(OP_READ, 12'd0);
    push_cmd(OP_READ, 12'd1);
    push_cmd(OP_READ, 12'd2);
    push_cmd(OP_READ, 12'hFFF);
    push_point(40'd86400, $urandom(), $urandom(), 16'($urandom()));
    push_point(40'd86401, $urandom(), $urandom(), 16'($urandom()));
    push_point(40'd5, $urandom(), $urandom(), 16'($urandom()));
    push_cmd(OP_READ, 12'd0);
    push_point(40'd100, $urandom(), $urandom(), 16'($urandom()));
    push_cmd(OP_PRUNE, '0);
    drain();

    // Zero window: only points at the newest stamp survive
    write_reg(CFG_WINDOW, 0);
    push_cmd(OP_PRUNE, '0);
    push_point(40'd86401, $urandom(), $urandom(), 16'($urandom()));
    push_point(40'd86402, $urandom(), $urandom(), 16'($urandom()));
    drain();

    // Zero limit: an add evicts everything, the new point too
    write_reg(CFG_MAX, 0);
    push_point(STAMP_TOP, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
    push_cmd(OP_READ, 12'd0);
    push_point('0, $urandom(), $urandom(), 16'($urandom()));
    drain();

    // Window wider than the newest stamp, limit above the depth
    write_reg(CFG_WINDOW, 16383);
    write_reg(CFG_MAX, 8191);
    push_point(40'd1000, $urandom(), $urandom(), 16'($urandom()));
    push_point(40'd1000, $urandom(), $urandom(), 16'($urandom()));
    push_cmd(OP_PRUNE, '0);
    push_cmd(OP_READ, 12'd1);
    push_cmd(OP_READ, 12'hFFF);
    drain();

    gen_stamp  = 40'd1000;
    send_idle  = 0;
    recv_stall = 0;
    write_reg(CFG_WINDOW, 1);
    write_reg(CFG_MAX, 8);
    push_cmd(OP_PRUNE, '0);
    gen_mix(85, 1500, 12);
    drain();

    send_idle  = 66;
    recv_stall = 0;
    write_reg(CFG_WINDOW, WINDOW_RST);
    write_reg(CFG_MAX, MAXCFG_RST);
    push_cmd(OP_PRUNE, '0);
    gen_mix(85, 30000, 40);
    drain();

    send_idle  = 0;
    recv_stall = 66;
    write_reg(CFG_WINDOW, 0);
    write_reg(CFG_MAX, 1);
    push_cmd(OP_PRUNE, '0);
    gen_mix(85, 5, 4);
    drain();

    // Pile up adds while the result channel is held off
    send_idle  = 0;
    recv_stall = 0;
    write_reg(CFG_WINDOW, 8760);
    write_reg(CFG_MAX, 8191);
    push_cmd(OP_PRUNE, '0);
    hold_req = hold_req + 1;
    for (int i = 0; i < 160; i++) begin
      advance_stamp($urandom_range(0, 3));
      push_point(gen_stamp, $urandom(), $urandom(), 16'($urandom()));
      if (i % 64 == 63) push_cmd(OP_READ, 12'($urandom()));
    end
    push_cmd(OP_READ, 12'hFFF);
    for (int i = 0; i < 40; i++) push_cmd(OP_READ, 12'($urandom()));
    drain();
    write_reg(CFG_MAX, 0);
    push_cmd(OP_PRUNE, '0);
    drain();

    send_idle  = 10;
    recv_stall = 10;
    gen_stamp  = {1'b0, 7'($urandom()), $urandom()};
    write_reg(CFG_WINDOW, 16383);
    write_reg(CFG_MAX, 8191);
    gen_mix(85, 1 << 20, 200);
    drain();

    write_reg(CFG_WINDOW, $urandom_range(0, 3));
    write_reg(CFG_MAX, $urandom_range(2, 40));
    push_cmd(OP_PRUNE, '0);
    gen_mix(85, 4000, 48);
    drain();

    $display("%0d words in, %0d out: %0d added %0d rejected %0d pruned %0d read %0d range",
             accepted, checked, status_seen[ST_ADDED], status_seen[ST_REJECTED],
             status_seen[ST_PRUNED], status_seen[ST_READ_OK], status_seen[ST_RANGE]);
    $display("%0d points evicted, store peak %0d points, %0d mismatches",
             evicted_total, peak_fill, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** time_window_track_buffer: PASSED **");
    end else begin
      $display("** time_window_track_buffer: FAILED **");
    end
    $finish;
  end

endmodule
